### src/stu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the source tokenizer
package stu_pkg;

   // token kinds
   localparam logic [3:0] KIND_NUMBER  = 4'd0;
   localparam logic [3:0] KIND_IDENT   = 4'd1;
   localparam logic [3:0] KIND_IF      = 4'd2;
   localparam logic [3:0] KIND_ELSE    = 4'd3;
   localparam logic [3:0] KIND_WHILE   = 4'd4;
   localparam logic [3:0] KIND_FOR     = 4'd5;
   localparam logic [3:0] KIND_RETURN  = 4'd6;
   localparam logic [3:0] KIND_PLUS    = 4'd7;
   localparam logic [3:0] KIND_MINUS   = 4'd8;
   localparam logic [3:0] KIND_LPAREN  = 4'd9;
   localparam logic [3:0] KIND_RPAREN  = 4'd10;
   localparam logic [3:0] KIND_UNKNOWN = 4'd11;
   localparam logic [3:0] KIND_END     = 4'd12;

   // most tokens one source byte can produce
   localparam int MAX_PUSH = 3;

   // token queue geometry, depth is a power of two
   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [23:0] offset;
      logic [7:0]  length;
      logic        final_res;
   } tok_type;

   // tokens made by one accepted beat, packed from slot 0
   typedef struct packed {
      logic [1:0]          count;
      tok_type [MAX_PUSH-1:0] tok;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              space;
   } q_stat_type;

endpackage

### src/stu_lexer.sv
`timescale 1ns / 1ps
// scanner state and per-byte token formation
module stu_lexer import stu_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 255,
   parameter int OFFSET_BITS   = 24,
   parameter int LINE_BITS     = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] ch,
   input  logic       last,
   output push_type   push
);

   localparam int OFF_W = (OFFSET_BITS < 24) ? OFFSET_BITS : 24;
   localparam int LN_W  = (LINE_BITS < 16) ? LINE_BITS : 16;
   localparam int LEN_MAX = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

   localparam logic [1:0] RUN_NONE  = 2'd0;
   localparam logic [1:0] RUN_NUM   = 2'd1;
   localparam logic [1:0] RUN_IDENT = 2'd2;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam int PREFIX_DEPTH = 6;

   logic [1:0]       run_type_ff, run_type_in;
   logic [7:0]       run_len_ff, run_len_in;
   logic             over_six_ff, over_six_in;
   logic [OFF_W-1:0] run_off_ff, run_off_in;
   logic [LN_W-1:0]  run_line_ff, run_line_in;
   logic [LN_W-1:0]  run_col_ff, run_col_in;
   logic [PREFIX_DEPTH-1:0][7:0] prefix_ff, prefix_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [LN_W-1:0]  line_ff, line_in;
   logic [LN_W-1:0]  col_ff, col_in;
   logic             ended_ff, ended_in;

   function automatic logic [3:0] word_kind(input logic [PREFIX_DEPTH-1:0][7:0] p,
                                            input logic [7:0] len, input logic over);
      logic [3:0] k;
      k = KIND_IDENT;
      if (!over) begin
         if (len == 8'd2 && {p[0], p[1]} == "if") k = KIND_IF;
         else if (len == 8'd4 && {p[0], p[1], p[2], p[3]} == "else") k = KIND_ELSE;
         else if (len == 8'd5 && {p[0], p[1], p[2], p[3], p[4]} == "while")
            k = KIND_WHILE;
         else if (len == 8'd3 && {p[0], p[1], p[2]} == "for") k = KIND_FOR;
         else if (len == 8'd6 && {p[0], p[1], p[2], p[3], p[4], p[5]} == "return")
            k = KIND_RETURN;
      end
      return k;
   endfunction

   always_comb begin
      logic       live, is_zero, dg, al, sp, early, end_now;
      logic [1:0] rt_mid;
      logic [7:0] len_mid;
      logic       over_mid;
      logic [3:0] single_kind;
      logic [3:0] cand_v;
      tok_type    cand [4];
      logic [2:0] n;

      run_type_in = run_type_ff;
      run_len_in  = run_len_ff;
      over_six_in = over_six_ff;
      run_off_in  = run_off_ff;
      run_line_in = run_line_ff;
      run_col_in  = run_col_ff;
      prefix_in   = prefix_ff;
      off_in      = off_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      ended_in    = ended_ff;
      cand_v      = '0;

      live    = accept && !ended_ff;
      is_zero = (ch == 8'd0);
      dg      = (ch >= "0") && (ch <= "9");
      al      = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"))
                || (ch == CH_UNDER);
      sp      = (ch == CH_SPACE) || ((ch >= 8'd9) && (ch <= 8'd13));

      // open run ends before this byte
      early = live && (run_type_ff != RUN_NONE) &&
              (is_zero || (run_type_ff == RUN_NUM && !dg) ||
               (run_type_ff == RUN_IDENT && !(dg || al)));
      cand[0] = '{kind: (run_type_ff == RUN_NUM) ? KIND_NUMBER :
                        word_kind(prefix_ff, run_len_ff, over_six_ff),
                  line: 16'(run_line_ff), column: 16'(run_col_ff),
                  offset: 24'(run_off_ff), length: run_len_ff, final_res: 1'b0};
      cand_v[0] = early;

      rt_mid   = early ? RUN_NONE : run_type_ff;
      len_mid  = early ? 8'd0 : run_len_ff;
      over_mid = early ? 1'b0 : over_six_ff;
      if (early) begin
         run_type_in = RUN_NONE;
         run_len_in  = 8'd0;
         over_six_in = 1'b0;
      end

      unique case (ch)
         CH_PLUS:   single_kind = KIND_PLUS;
         CH_MINUS:  single_kind = KIND_MINUS;
         CH_LPAREN: single_kind = KIND_LPAREN;
         CH_RPAREN: single_kind = KIND_RPAREN;
         default:   single_kind = KIND_UNKNOWN;
      endcase
      cand[1] = '{kind: single_kind, line: 16'(line_ff), column: 16'(col_ff),
                  offset: 24'(off_ff), length: 8'd1, final_res: 1'b0};

      if (live && !is_zero) begin
         if (rt_mid != RUN_NONE) begin
            if (rt_mid == RUN_IDENT) begin
               if (len_mid < 8'(PREFIX_DEPTH) && !over_mid)
                  prefix_in[len_mid[2:0]] = ch;
               else
                  over_six_in = 1'b1;
            end
            if (len_mid < 8'(LEN_MAX)) run_len_in = len_mid + 8'd1;
         end else if (dg || al) begin
            run_type_in  = dg ? RUN_NUM : RUN_IDENT;
            run_len_in   = 8'd1;
            over_six_in  = 1'b0;
            prefix_in[0] = ch;
            run_off_in   = off_ff;
            run_line_in  = line_ff;
            run_col_in   = col_ff;
         end else if (!sp) begin
            cand_v[1] = 1'b1;
         end

         if (off_ff != '1) off_in = off_ff + 1'b1;
         if (ch == CH_NL) begin
            if (line_ff != '1) line_in = line_ff + 1'b1;
            col_in = '0;
         end else if (col_ff != '1) begin
            col_in = col_ff + 1'b1;
         end
      end

      // end of source closes whatever run this byte left open
      end_now = live && (is_zero || last);
      cand[2] = '{kind: (run_type_in == RUN_NUM) ? KIND_NUMBER :
                        word_kind(prefix_in, run_len_in, over_six_in),
                  line: 16'(run_line_in), column: 16'(run_col_in),
                  offset: 24'(run_off_in), length: run_len_in, final_res: 1'b0};
      cand_v[2] = end_now && (run_type_in != RUN_NONE);
      cand[3] = '{kind: KIND_END, line: 16'(line_in), column: 16'(col_in),
                  offset: 24'(off_in), length: 8'd0, final_res: 1'b1};
      cand_v[3] = end_now;
      if (end_now) begin
         ended_in    = 1'b1;
         run_type_in = RUN_NONE;
         run_len_in  = 8'd0;
         over_six_in = 1'b0;
      end

      push = '0;
      n    = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i]) begin
            if (n < 3'(MAX_PUSH)) push.tok[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      push.count = n[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_type_ff <= RUN_NONE;
         run_len_ff  <= 8'd0;
         over_six_ff <= 1'b0;
         off_ff      <= '0;
         line_ff     <= '0;
         col_ff      <= '0;
         ended_ff    <= 1'b0;
      end else begin
         run_type_ff <= run_type_in;
         run_len_ff  <= run_len_in;
         over_six_ff <= over_six_in;
         off_ff      <= off_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         ended_ff    <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      run_off_ff  <= run_off_in;
      run_line_ff <= run_line_in;
      run_col_ff  <= run_col_in;
      prefix_ff   <= prefix_in;
   end

endmodule

### src/stu_token_queue.sv
`timescale 1ns / 1ps
// token queue taking up to three tokens a cycle and giving one
module stu_token_queue import stu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output tok_type    head,
   output q_stat_type stat
);

   tok_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   assign head       = q_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   // room for the worst-case beat, ignoring a pop in the same cycle
   assign stat.space = (count_ff <= QCNT_W'(QDEPTH - MAX_PUSH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < push.count) q_ff[wr_ptr_ff + QPTR_W'(i)] <= push.tok[i];
      end
   end

endmodule

### src/source_tokenizer_unit.sv
`timescale 1ns / 1ps
// top level of the source tokenizer
//
// req channel: one source byte per beat (req_ch, req_last). A zero byte or
// a beat with req_last set ends the source; later beats are taken and dropped
// until reset.
// rsp channel: one token per beat with kind, start line, column, byte offset
// and length; the end token has length zero and rsp_final_res set.
// A byte is scanned in the cycle it is taken against the scanner state and
// its tokens (up to three) land in an 8-entry queue; the first one is on
// rsp in the cycle after the byte if the queue was empty, and rsp_valid
// comes straight off the queue. Throughput is one byte per cycle while the
// queue has room for three more tokens; req_ready drops when six or more wait,
// so a stalled receiver backs up into the byte stream and nothing is lost.
// Reset (synchronous) clears the scanner position, the open run and the
// queue; the block takes bytes in the cycle after reset is released.
module source_tokenizer_unit import stu_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 255,
   parameter int OFFSET_BITS   = 24,
   parameter int LINE_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [15:0] rsp_line,
   output logic [15:0] rsp_column,
   output logic [23:0] rsp_offset,
   output logic [7:0]  rsp_length,
   output logic        rsp_final_res
);

   push_type   push;
   q_stat_type stat;
   tok_type    head;
   logic       accept;
   logic       pop;

   assign req_ready = stat.space;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (stat.count != '0);
   assign pop       = rsp_valid && rsp_ready;

   stu_lexer #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
      .OFFSET_BITS  (OFFSET_BITS),
      .LINE_BITS    (LINE_BITS)
   ) u_lexer (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .ch    (req_ch),
      .last  (req_last),
      .push  (push)
   );

   stu_token_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .head (head),
      .stat (stat)
   );

   assign rsp_kind      = head.kind;
   assign rsp_line      = head.line;
   assign rsp_column    = head.column;
   assign rsp_offset    = head.offset;
   assign rsp_length    = head.length;
   assign rsp_final_res = head.final_res;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.count <= QCNT_W'(QDEPTH))
      else $error("token queue overflow");

   a_push_needs_beat: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.count == 2'd0)
      else $error("tokens produced without an accepted beat");

   a_end_token_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END |-> rsp_final_res && rsp_length == 8'd0)
      else $error("malformed end token");

   a_final_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_res |-> rsp_kind == KIND_END)
      else $error("final flag on a token other than end");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !accept && !pop |=> $stable(stat.count))
      else $error("queue count moved without push or pop");

endmodule
